// ----- design/jmcc_pkg.sv -----
`timescale 1ns / 1ps

package jmcc_pkg;

    // MCU buffer geometry
    localparam int MAX_BLOCKS  = 10;
    localparam int BLOCK_AW    = 6;                      // 64 samples per 8x8 block
    localparam int BUF_DEPTH   = MAX_BLOCKS * (1 << BLOCK_AW);
    localparam int BUF_AW      = $clog2(BUF_DEPTH);

    // full computed address: base block (4 bits) * 64 plus row/column offset up to 135
    localparam int FULL_AW     = 11;

    // fixed field widths
    localparam int SAMPLE_W    = 8;
    localparam int INDEX_W     = 10;
    localparam int POS_W       = 4;                      // row / column within the MCU
    localparam int CLIP_W      = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 6;

    localparam int MAX_ROW_PIXELS = 16;
    localparam logic [SAMPLE_W-1:0] ALPHA_OPAQUE = 8'hFF;

endpackage

// ----- design/jmcc_ram.sv -----
`timescale 1ns / 1ps

module jmcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 640
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/jpeg_mcu_color_convert.sv -----
`timescale 1ns / 1ps

// MCU color converter: 8-bit YCbCr (or Y,Cb,Cr,K) samples to BGRA pixels.
// Input channel (in_valid / in_stall): func 0 writes one sample into the
// 640-entry MCU buffer at sample_index (indexes past the buffer are dropped);
// func 1 converts one pixel row and returns up to 16 pixels in column order.
// Output channel (out_valid / out_stall): one pixel per request, last marks
// the final pixel of the row. Config port (cfg_valid / cfg_ready, always
// ready) writes a register by index; write it only while the block is idle.
// A load is written to the buffer as it is taken. For each pixel the
// sequencer reads Y, Cb, Cr (and K) from the single buffer read port, one
// sample per cycle, then runs a five-stage multiply pipeline; the next
// pixel is not read until the last one is in the output register.
// in_stall is high while a row is in work; a row outside the clip is
// dropped without raising in_stall. A stalled output holds its pixel and
// the sequencer waits for it; a new request may be taken while the last
// pixel of a row is still waiting.
// Reset returns the registers to their defaults and the sequencer to idle;
// buffer contents are undefined until loaded.

module jpeg_mcu_color_convert (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic [jmcc_pkg::INDEX_W-1:0]    sample_index,
    input  logic [jmcc_pkg::SAMPLE_W-1:0]   sample,
    input  logic [jmcc_pkg::POS_W-1:0]      row,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [jmcc_pkg::SAMPLE_W-1:0]   blue,
    output logic [jmcc_pkg::SAMPLE_W-1:0]   green,
    output logic [jmcc_pkg::SAMPLE_W-1:0]   red,
    output logic [jmcc_pkg::SAMPLE_W-1:0]   alpha,
    output logic [jmcc_pkg::POS_W-1:0]      column,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [jmcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jmcc_pkg::CFG_DATA_W-1:0] cfg_data
);

    import jmcc_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CALC, ST_OUT} state_t;
    typedef enum logic [1:0] {COMP_Y, COMP_CB, COMP_CR, COMP_K} comp_t;
    typedef enum logic [2:0] {
        REG_CMYK_MODE, REG_LUMA_COLS, REG_CLIP_WIDTH, REG_CLIP_HEIGHT,
        REG_CB_BASE, REG_CR_BASE, REG_K_BASE, REG_SUBSAMPLE
    } reg_idx_t;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EMIT = 1'b1;

    localparam int CH_B = 0;
    localparam int CH_G = 1;
    localparam int CH_R = 2;

    // capture + five arithmetic stages
    localparam logic [2:0] CALC_LAST = 3'd5;

    // shift-factor bits
    localparam int SH_CB_X = 0;
    localparam int SH_CB_Y = 1;
    localparam int SH_CR_X = 2;
    localparam int SH_CR_Y = 3;
    localparam int SH_K_X  = 4;
    localparam int SH_K_Y  = 5;

    // ---------------- configuration ----------------
    logic                 cmyk_reg;
    logic [1:0]           luma_cols_reg;
    logic [CLIP_W-1:0]    clip_w_reg;
    logic [CLIP_W-1:0]    clip_h_reg;
    logic [3:0]           cb_base_reg;
    logic [3:0]           cr_base_reg;
    logic [3:0]           k_base_reg;
    logic [5:0]           shifts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmyk_reg      <= 1'b0;
            luma_cols_reg <= 2'd1;
            clip_w_reg    <= CLIP_W'(8);
            clip_h_reg    <= CLIP_W'(8);
            cb_base_reg   <= 4'd1;
            cr_base_reg   <= 4'd2;
            k_base_reg    <= 4'd3;
            shifts_reg    <= 6'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_CMYK_MODE:   cmyk_reg      <= cfg_data[0];
                REG_LUMA_COLS:   luma_cols_reg <= cfg_data[1:0];
                REG_CLIP_WIDTH:  clip_w_reg    <= cfg_data[CLIP_W-1:0];
                REG_CLIP_HEIGHT: clip_h_reg    <= cfg_data[CLIP_W-1:0];
                REG_CB_BASE:     cb_base_reg   <= cfg_data[3:0];
                REG_CR_BASE:     cr_base_reg   <= cfg_data[3:0];
                REG_K_BASE:      k_base_reg    <= cfg_data[3:0];
                REG_SUBSAMPLE:   shifts_reg    <= cfg_data[5:0];
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // ---------------- request decode ----------------
    state_t               state_reg;
    comp_t                phase_reg;
    logic [2:0]           cnt_reg;
    logic [POS_W-1:0]     x_reg;
    logic [POS_W-1:0]     row_reg;
    logic [CLIP_W-1:0]    w_reg;
    logic                 cap_en_reg;
    comp_t                cap_sel_reg;
    logic                 cap_zero_reg;
    logic                 out_valid_reg;
    logic [SAMPLE_W-1:0]  blue_reg;
    logic [SAMPLE_W-1:0]  green_reg;
    logic [SAMPLE_W-1:0]  red_reg;
    logic [POS_W-1:0]     column_reg;
    logic                 last_reg;

    logic                 in_accept;
    logic                 load_we;
    logic                 emit_go;
    logic [CLIP_W-1:0]    w_eff;
    logic                 pix_last;
    comp_t                last_comp;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign w_eff     = (clip_w_reg > CLIP_W'(MAX_ROW_PIXELS)) ? CLIP_W'(MAX_ROW_PIXELS)
                                                                : clip_w_reg;
    assign load_we   = in_accept && (func == FUNC_LOAD)
                       && (32'(sample_index) < BUF_DEPTH);
    assign emit_go   = in_accept && (func == FUNC_EMIT)
                       && ({1'b0, row} < clip_h_reg) && (w_eff != '0);
    assign pix_last  = ((CLIP_W'(x_reg) + CLIP_W'(1)) == w_reg);
    assign last_comp = cmyk_reg ? COMP_K : COMP_CR;

    // ---------------- buffer addressing ----------------
    // (yb*(8>>ys) + (yi>>ys)) collapses to row>>ys, same for columns
    function automatic logic [FULL_AW-1:0] chroma_addr(
        input logic [3:0]       base,
        input logic             xs,
        input logic             ys,
        input logic [POS_W-1:0] r,
        input logic [POS_W-1:0] c
    );
        logic [POS_W-1:0] rs;
        logic [POS_W-1:0] cs;
        rs = ys ? (r >> 1) : r;
        cs = xs ? (c >> 1) : c;
        return (FULL_AW'(base) << BLOCK_AW) + (FULL_AW'(rs) << 3) + FULL_AW'(cs);
    endfunction

    logic [3:0]           luma_blk;
    logic [FULL_AW-1:0]   rd_addr_full;
    logic                 rd_oob;
    logic [SAMPLE_W-1:0]  ram_rdata;

    always_comb
    begin
        if (luma_cols_reg[1])
        begin
            luma_blk = {2'b00, row_reg[3], x_reg[3]};
        end
        else
        begin
            luma_blk = 4'(row_reg[3]) + 4'(x_reg[3]);
        end

        unique case (phase_reg)
            COMP_Y:  rd_addr_full = FULL_AW'({luma_blk, row_reg[2:0], x_reg[2:0]});
            COMP_CB: rd_addr_full = chroma_addr(cb_base_reg, shifts_reg[SH_CB_X],
                                                shifts_reg[SH_CB_Y], row_reg, x_reg);
            COMP_CR: rd_addr_full = chroma_addr(cr_base_reg, shifts_reg[SH_CR_X],
                                                shifts_reg[SH_CR_Y], row_reg, x_reg);
            COMP_K:  rd_addr_full = chroma_addr(k_base_reg, shifts_reg[SH_K_X],
                                                shifts_reg[SH_K_Y], row_reg, x_reg);
        endcase
        rd_oob = (rd_addr_full >= FULL_AW'(BUF_DEPTH));
    end

    jmcc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (load_we),
        .waddr (sample_index[BUF_AW-1:0]),
        .wdata (sample),
        .raddr (rd_addr_full[BUF_AW-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------- sequencer ----------------
    logic [SAMPLE_W-1:0]  res5_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= COMP_Y;
            cnt_reg       <= '0;
            x_reg         <= '0;
            row_reg       <= '0;
            w_reg         <= '0;
            cap_en_reg    <= 1'b0;
            cap_sel_reg   <= COMP_Y;
            cap_zero_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            blue_reg      <= '0;
            green_reg     <= '0;
            red_reg       <= '0;
            column_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            cap_en_reg   <= (state_reg == ST_READ);
            cap_sel_reg  <= phase_reg;
            cap_zero_reg <= rd_oob;

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (emit_go)
                    begin
                        row_reg   <= row;
                        w_reg     <= w_eff;
                        x_reg     <= '0;
                        phase_reg <= COMP_Y;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    if (phase_reg == last_comp)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_CALC;
                    end
                    else
                    begin
                        phase_reg <= comp_t'(phase_reg + 2'd1);
                    end
                end
                ST_CALC:
                begin
                    if (cnt_reg == CALC_LAST)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        blue_reg      <= res5_reg[CH_B];
                        green_reg     <= res5_reg[CH_G];
                        red_reg       <= res5_reg[CH_R];
                        column_reg    <= x_reg;
                        last_reg      <= pix_last;
                        if (pix_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            x_reg     <= x_reg + POS_W'(1);
                            phase_reg <= COMP_Y;
                            state_reg <= ST_READ;
                        end
                    end
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign blue      = blue_reg;
    assign green     = green_reg;
    assign red       = red_reg;
    assign alpha     = ALPHA_OPAQUE;
    assign column    = column_reg;
    assign last      = last_reg;

    // ---------------- conversion pipeline ----------------
    logic [SAMPLE_W-1:0]  samp_reg [4];

    logic signed [27:0]   pr1_reg;
    logic signed [27:0]   pg1_reg;
    logic signed [27:0]   pg2_reg;
    logic signed [27:0]   pb1_reg;
    logic [SAMPLE_W-1:0]  y1_reg;
    logic [SAMPLE_W-1:0]  k1_reg;

    logic signed [9:0]    chan2_reg [3];
    logic [SAMPLE_W-1:0]  y2_reg;
    logic [SAMPLE_W-1:0]  k2_reg;

    logic signed [19:0]   prod3_reg [3];
    logic [SAMPLE_W-1:0]  ycc3_reg [3];

    logic [9:0]           q4_reg [3];
    logic                 neg4_reg [3];
    logic [SAMPLE_W-1:0]  ycc4_reg [3];

    logic signed [27:0]   t_r;
    logic signed [27:0]   t_g;
    logic signed [27:0]   t_b;
    logic signed [9:0]    chan2_next [3];
    logic signed [19:0]   prod3_next [3];
    logic [SAMPLE_W-1:0]  ycc3_next [3];
    logic [9:0]           q4_next [3];
    logic [SAMPLE_W-1:0]  res5_next [3];

    function automatic logic [SAMPLE_W-1:0] clamp8(input logic signed [10:0] v);
        logic [SAMPLE_W-1:0] c;
        if (v < 0)
        begin
            c = '0;
        end
        else if (v > 11'sd255)
        begin
            c = 8'hFF;
        end
        else
        begin
            c = v[SAMPLE_W-1:0];
        end
        return c;
    endfunction

    always_comb
    begin
        // floor(x / 65536) is the bit slice of the two's complement sum
        t_r = pr1_reg - 28'sd11711232;
        t_g = pg1_reg + pg2_reg + 28'sd8874368;
        t_b = pb1_reg - 28'sd14773120;
        chan2_next[CH_R] = t_r[25:16];
        chan2_next[CH_G] = t_g[25:16];
        chan2_next[CH_B] = t_b[25:16];

        for (int i = 0; i < 3; i++)
        begin
            logic signed [10:0] s;
            logic signed [19:0] v;
            logic signed [19:0] a;
            logic [34:0]        qf;

            s = 11'(chan2_reg[i]) + $signed({3'b000, y2_reg});
            ycc3_next[i] = clamp8(s);
            v = 20'sd255 - 20'(chan2_reg[i]) - $signed({12'd0, y2_reg});
            prod3_next[i] = v * $signed({12'd0, k2_reg});

            // |p| / 255 for |p| < 2^17: ceil(2^25/255) reciprocal is exact there
            a  = prod3_reg[i][19] ? -prod3_reg[i] : prod3_reg[i];
            qf = 35'(a[16:0]) * 35'd131587;
            q4_next[i] = qf[34:25];

            if (!cmyk_reg)
            begin
                res5_next[i] = ycc4_reg[i];
            end
            else if (neg4_reg[i])
            begin
                res5_next[i] = '0;
            end
            else if (q4_reg[i] > 10'd255)
            begin
                res5_next[i] = 8'hFF;
            end
            else
            begin
                res5_next[i] = q4_reg[i][SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_en_reg)
        begin
            samp_reg[cap_sel_reg] <= cap_zero_reg ? '0 : ram_rdata;
        end

        pr1_reg <= $signed({20'd0, samp_reg[COMP_CR]}) * 28'sd91750;
        pg1_reg <= $signed({20'd0, samp_reg[COMP_CB]}) * -28'sd22479;
        pg2_reg <= $signed({20'd0, samp_reg[COMP_CR]}) * -28'sd46596;
        pb1_reg <= $signed({20'd0, samp_reg[COMP_CB]}) * 28'sd115671;
        y1_reg  <= samp_reg[COMP_Y];
        k1_reg  <= samp_reg[COMP_K];

        y2_reg  <= y1_reg;
        k2_reg  <= k1_reg;

        for (int i = 0; i < 3; i++)
        begin
            chan2_reg[i] <= chan2_next[i];
            prod3_reg[i] <= prod3_next[i];
            ycc3_reg[i]  <= ycc3_next[i];
            q4_reg[i]    <= q4_next[i];
            neg4_reg[i]  <= prod3_reg[i][19];
            ycc4_reg[i]  <= ycc3_reg[i];
            res5_reg[i]  <= res5_next[i];
        end
    end

    // ---------------- assertions ----------------
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> ({1'b0, x_reg} < w_reg))
    else $error("pixel column ran past the clipped width");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_READ) && !cmyk_reg) |-> (phase_reg != COMP_K))
    else $error("K sample read in YCbCr mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        cap_en_reg |-> $past(state_reg == ST_READ))
    else $error("sample capture without a buffer read");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
    else $error("pixel presented outside the output step");

endmodule
